[hdl/usf_pkg.sv]
package usf_pkg;

  typedef logic [20:0] cp_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       text_last;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       run_last;
    logic       text_end;
  } out_t;

  // scan of the byte window: one code point slot per window position
  typedef struct packed {
    logic [3:0]      cp_vld;
    cp_t [3:0]       cp;
    logic [1:0]      pend_cnt;
    logic [2:0][7:0] pend_buf;
  } scan_t;

  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      cnt;
  } emit_t;

  localparam logic [7:0] ASCII_LIMIT = 8'h80;
  localparam logic [7:0] CONT_TAG    = 8'h80;
  localparam logic [7:0] LEAD2_TAG   = 8'hC0;
  localparam logic [7:0] LEAD3_TAG   = 8'hE0;
  localparam logic [7:0] LEAD4_TAG   = 8'hF0;
  localparam cp_t        CP_NEWLINE  = 21'h0000A;
  localparam cp_t        CP_SPACE    = 21'h00020;
  localparam cp_t        CP_DEL      = 21'h0007F;
  localparam cp_t        CP_C1_LO    = 21'h00080;
  localparam cp_t        CP_C1_HI    = 21'h0009F;
  localparam cp_t        CP_TWO_MAX  = 21'h007FF;
  localparam cp_t        CP_THREE_MAX = 21'h0FFFF;

  localparam int NUM_DROP_SPANS = 24;

  localparam cp_t DROP_LO [NUM_DROP_SPANS] = '{
    21'h00300, 21'h00483, 21'h00591, 21'h00610, 21'h0064B, 21'h00670,
    21'h006D6, 21'h00730, 21'h007EB, 21'h0135D, 21'h01AB0, 21'h01DC0,
    21'h020D0, 21'h0FE20, 21'h0200B, 21'h02028, 21'h02060, 21'h02066,
    21'h0FE00, 21'h0FEFF, 21'h0FFF9, 21'h1D173, 21'hE0000, 21'hE0100
  };

  localparam cp_t DROP_HI [NUM_DROP_SPANS] = '{
    21'h0036F, 21'h00489, 21'h005C7, 21'h0061A, 21'h0065F, 21'h00670,
    21'h006ED, 21'h0074A, 21'h007F3, 21'h0135F, 21'h01AFF, 21'h01DFF,
    21'h020F0, 21'h0FE2F, 21'h0200F, 21'h0202E, 21'h02064, 21'h0206F,
    21'h0FE0F, 21'h0FEFF, 21'h0FFFB, 21'h1D17A, 21'hE007F, 21'hE01EF
  };

  // total sequence length announced by a lead byte, 0 when not a lead
  function automatic logic [2:0] lead_len(input logic [7:0] b);
    logic [2:0] r;
    if (b inside {[8'hC0:8'hDF]}) begin
      r = 3'd2;
    end else if (b inside {[8'hE0:8'hEF]}) begin
      r = 3'd3;
    end else if (b inside {[8'hF0:8'hF7]}) begin
      r = 3'd4;
    end else begin
      r = 3'd0;
    end
    return r;
  endfunction

  function automatic cp_t cp_decode(input logic [3:0][7:0] w, input logic [2:0] len);
    cp_t r;
    case (len)
      3'd2:    r = {10'b0, w[0][4:0], w[1][5:0]};
      3'd3:    r = {5'b0, w[0][3:0], w[1][5:0], w[2][5:0]};
      default: r = {w[0][2:0], w[1][5:0], w[2][5:0], w[3][5:0]};
    endcase
    return r;
  endfunction

  function automatic logic is_dropped(input cp_t cp);
    logic hit;
    hit = (cp < CP_SPACE) || (cp == CP_DEL) || (cp >= CP_C1_LO && cp <= CP_C1_HI);
    for (int k = 0; k < NUM_DROP_SPANS; k++) begin
      if (cp >= DROP_LO[k] && cp <= DROP_HI[k]) begin
        hit = 1'b1;
      end
    end
    if (cp == CP_NEWLINE) begin
      hit = 1'b0;
    end
    return hit;
  endfunction

  function automatic logic [2:0] enc_len(input cp_t cp);
    logic [2:0] r;
    if (cp < cp_t'(ASCII_LIMIT)) begin
      r = 3'd1;
    end else if (cp <= CP_TWO_MAX) begin
      r = 3'd2;
    end else if (cp <= CP_THREE_MAX) begin
      r = 3'd3;
    end else begin
      r = 3'd4;
    end
    return r;
  endfunction

  // shortest form, byte 0 first
  function automatic logic [3:0][7:0] enc_bytes(input cp_t cp);
    logic [3:0][7:0] r;
    r = '0;
    if (cp < cp_t'(ASCII_LIMIT)) begin
      r[0] = cp[7:0];
    end else if (cp <= CP_TWO_MAX) begin
      r[0] = LEAD2_TAG | {3'b0, cp[10:6]};
      r[1] = CONT_TAG | {2'b0, cp[5:0]};
    end else if (cp <= CP_THREE_MAX) begin
      r[0] = LEAD3_TAG | {4'b0, cp[15:12]};
      r[1] = CONT_TAG | {2'b0, cp[11:6]};
      r[2] = CONT_TAG | {2'b0, cp[5:0]};
    end else begin
      r[0] = LEAD4_TAG | {5'b0, cp[20:18]};
      r[1] = CONT_TAG | {2'b0, cp[17:12]};
      r[2] = CONT_TAG | {2'b0, cp[11:6]};
      r[3] = CONT_TAG | {2'b0, cp[5:0]};
    end
    return r;
  endfunction

endpackage

[hdl/usf_scan.sv]
module usf_scan import usf_pkg::*; (
  input  logic [1:0]      pend_cnt_i,
  input  logic [2:0][7:0] pend_buf_i,
  input  logic [7:0]      byte_i,
  output scan_t           scan_o
);

  logic [6:0][7:0] win;
  logic [2:0]      n;
  logic [2:0]      nxt;
  logic            stop;
  logic [7:0]      b;
  logic [2:0]      len;
  logic [2:0]      bad;

  // window = pending bytes followed by the new byte, scanned from a fresh state
  always_comb begin
    win = '0;
    for (int idx = 0; idx < 4; idx++) begin
      if (3'(idx) < {1'b0, pend_cnt_i}) begin
        win[idx] = pend_buf_i[idx];
      end else if (3'(idx) == {1'b0, pend_cnt_i}) begin
        win[idx] = byte_i;
      end
    end
    n = {1'b0, pend_cnt_i} + 3'd1;

    scan_o   = '0;
    nxt      = '0;
    stop     = 1'b0;
    b        = '0;
    len      = '0;
    bad      = '0;
    for (int i = 0; i < 4; i++) begin
      if (!stop && nxt == 3'(i) && 3'(i) < n) begin
        b   = win[i];
        len = lead_len(b);
        if (b < ASCII_LIMIT) begin
          scan_o.cp_vld[i] = 1'b1;
          scan_o.cp[i]     = {13'b0, b};
          nxt              = 3'(i) + 3'd1;
        end else if (len == 3'd0) begin
          nxt = 3'(i) + 3'd1;
        end else if (3'(i) + len > n) begin
          // sequence still incomplete: keep it pending
          stop            = 1'b1;
          scan_o.pend_cnt = 2'(n - 3'(i));
          for (int k = 0; k < 3; k++) begin
            scan_o.pend_buf[k] = win[i + k];
          end
        end else begin
          bad = '0;
          for (int k = 3; k >= 1; k--) begin
            if (3'(k) < len && win[i + k][7:6] != 2'b10) begin
              bad = 3'(k);
            end
          end
          if (bad == 3'd0) begin
            scan_o.cp_vld[i] = 1'b1;
            scan_o.cp[i]     = cp_decode({win[i + 3], win[i + 2], win[i + 1], win[i]}, len);
            nxt              = 3'(i) + len;
          end else begin
            // drop the lead, restart at the first bad continuation
            nxt = 3'(i) + bad;
          end
        end
      end
    end
  end

endmodule

[hdl/usf_emit.sv]
module usf_emit import usf_pkg::*; (
  input  logic [3:0] cp_vld_i,
  input  cp_t [3:0]  cp_i,
  output emit_t      emit_o
);

  logic [3:0][2:0]       slot_len;
  logic [3:0][3:0][7:0]  slot_bytes;
  logic [4:0][4:0]       start;
  logic [4:0]            pos;

  always_comb begin
    for (int s = 0; s < 4; s++) begin
      slot_bytes[s] = enc_bytes(cp_i[s]);
      if (cp_vld_i[s] && !is_dropped(cp_i[s])) begin
        slot_len[s] = enc_len(cp_i[s]);
      end else begin
        slot_len[s] = 3'd0;
      end
    end

    start[0] = '0;
    for (int s = 0; s < 4; s++) begin
      start[s + 1] = start[s] + {2'b0, slot_len[s]};
    end

    // pack in order, anything past the fourth byte is lost
    emit_o = '0;
    pos    = '0;
    for (int s = 0; s < 4; s++) begin
      for (int e = 0; e < 4; e++) begin
        pos = start[s] + 5'(e);
        if (3'(e) < slot_len[s] && pos < 5'd4) begin
          emit_o.bytes[pos[1:0]] = slot_bytes[s][e];
        end
      end
    end
    emit_o.cnt = (start[4] > 5'd4) ? 3'd4 : start[4][2:0];
  end

endmodule

[hdl/utf8_sanitize_filter_top.sv]
// utf8_sanitize_filter_top: streaming UTF-8 sanitizer.
// input channel: one text byte per item (in_byte, text_last marks the final
// byte). output channel: one sanitized byte per item, run_last on the last byte
// produced by an input byte, text_end on the last byte of the text. A final
// input byte that produces nothing gives one bare end item with byte_valid 0.
// pipeline: input register, then decode/filter/encode combinationally into a
// result group register that holds up to four output bytes. An item waits in
// the input register until the group register is free, which then offers its
// first result. One input item per cycle is taken while the output does not
// stall and each produces at most one output byte; an item producing several
// bytes holds the group register until all its bytes are taken, and items
// producing no output item pass straight through even while a group is
// waiting. Bytes of an incomplete multi-byte sequence are held in a 3-byte
// pending buffer until it completes. reset clears the pending sequence count
// and the valids of both registers. a stalled output holds the current group;
// the input register then fills and in_ready_o drops until the group drains.
module utf8_sanitize_filter_top import usf_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_o
);

  in_t             in_q;
  logic            in_valid_q;
  logic [1:0]      pend_cnt_q;
  logic [2:0][7:0] pend_buf_q;
  logic            grp_valid_q;
  logic [3:0][7:0] grp_bytes_q;
  logic [2:0]      grp_cnt_q;
  logic [1:0]      grp_rd_q;
  logic            grp_data_q;
  logic            grp_last_q;

  scan_t scan;
  emit_t emit;
  logic  needs_out;
  logic  mark;
  logic  take;
  logic  run_last;
  logic  grp_done;
  logic  grp_free;
  logic  consume;

  usf_scan u_scan (
    .pend_cnt_i (pend_cnt_q),
    .pend_buf_i (pend_buf_q),
    .byte_i     (in_q.in_byte),
    .scan_o     (scan)
  );

  usf_emit u_emit (
    .cp_vld_i (scan.cp_vld),
    .cp_i     (scan.cp),
    .emit_o   (emit)
  );

  assign mark      = (emit.cnt == 3'd0) && in_q.text_last;
  assign needs_out = (emit.cnt != 3'd0) || in_q.text_last;
  assign run_last  = ({1'b0, grp_rd_q} + 3'd1) == grp_cnt_q;
  assign take      = grp_valid_q && out_ready_i;
  assign grp_done  = take && run_last;
  assign grp_free  = !grp_valid_q || grp_done;
  assign consume   = in_valid_q && (grp_free || !needs_out);
  assign in_ready_o = !in_valid_q || consume;

  assign out_valid_o      = grp_valid_q;
  assign out_o.out_byte   = grp_bytes_q[grp_rd_q];
  assign out_o.byte_valid = grp_data_q;
  assign out_o.run_last   = run_last;
  assign out_o.text_end   = run_last && grp_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      pend_cnt_q  <= '0;
      grp_valid_q <= 1'b0;
      grp_rd_q    <= '0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        in_valid_q <= 1'b1;
      end else if (consume) begin
        in_valid_q <= 1'b0;
      end

      if (consume) begin
        pend_cnt_q <= in_q.text_last ? 2'd0 : scan.pend_cnt;
      end

      if (consume && needs_out) begin
        grp_valid_q <= 1'b1;
        grp_rd_q    <= '0;
      end else if (grp_done) begin
        grp_valid_q <= 1'b0;
      end else if (take) begin
        grp_rd_q <= grp_rd_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_i;
    end
    if (consume) begin
      pend_buf_q <= scan.pend_buf;
    end
    if (consume && needs_out) begin
      grp_bytes_q <= mark ? '0 : emit.bytes;
      grp_cnt_q   <= mark ? 3'd1 : emit.cnt;
      grp_data_q  <= !mark;
      grp_last_q  <= in_q.text_last;
    end
  end

  a_rd_in_group: assert property (@(posedge clk_i) disable iff (!rst_ni)
    grp_valid_q |-> ({1'b0, grp_rd_q} < grp_cnt_q))
    else $error("group read index past group size");

  a_last_clears_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    consume && in_q.text_last |=> pend_cnt_q == 2'd0)
    else $error("pending sequence survived end of text");

  a_pending_head_lead: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_cnt_q != 2'd0 |-> lead_len(pend_buf_q[0]) > {1'b0, pend_cnt_q})
    else $error("pending buffer does not start with an unfinished lead");

  a_stall_holds_group: assert property (@(posedge clk_i) disable iff (!rst_ni)
    grp_valid_q && !out_ready_i |=> grp_valid_q && $stable(grp_rd_q))
    else $error("group changed while output stalled");

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps
module tb;
  import usf_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned PHASE_BYTES = 75;
  localparam int unsigned NUM_BORDER = 27;

  // code points on either side of the drop ranges and of the length limits
  localparam bit [20:0] BORDER_CPS [NUM_BORDER] = '{
    21'h0000A, 21'h00009, 21'h0001F, 21'h00020, 21'h0007E, 21'h0009F, 21'h000A0,
    21'h002FF, 21'h00300, 21'h0036F, 21'h00370, 21'h00670, 21'h007FF, 21'h00800,
    21'h0200B, 21'h0200F, 21'h02010, 21'h02065, 21'h0FEFF, 21'h0FFFF, 21'h10000,
    21'h1D17A, 21'hE007F, 21'hE0100, 21'hE01EF, 21'hE01F0, 21'h1FFFFF
  };

  class sanitize_tracker;
    bit [20:0] span_lo [24] = '{
      21'h00300, 21'h00483, 21'h00591, 21'h00610, 21'h0064B, 21'h00670,
      21'h006D6, 21'h00730, 21'h007EB, 21'h0135D, 21'h01AB0, 21'h01DC0,
      21'h020D0, 21'h0FE20, 21'h0200B, 21'h02028, 21'h02060, 21'h02066,
      21'h0FE00, 21'h0FEFF, 21'h0FFF9, 21'h1D173, 21'hE0000, 21'hE0100
    };
    bit [20:0] span_hi [24] = '{
      21'h0036F, 21'h00489, 21'h005C7, 21'h0061A, 21'h0065F, 21'h00670,
      21'h006ED, 21'h0074A, 21'h007F3, 21'h0135F, 21'h01AFF, 21'h01DFF,
      21'h020F0, 21'h0FE2F, 21'h0200F, 21'h0202E, 21'h02064, 21'h0206F,
      21'h0FE0F, 21'h0FEFF, 21'h0FFFB, 21'h1D17A, 21'hE007F, 21'hE01EF
    };
    bit [7:0] seq_buf [4];
    int unsigned seq_cnt;
    int unsigned seq_len;
    bit [7:0] step_bytes [$];
    out_t expected_bytes [$];
    int unsigned mismatches;
    int unsigned bytes_in;
    int unsigned bytes_out;

    function bit hidden_cp(bit [20:0] cp);
      if (cp == 21'h0A) return 1'b0;
      if (cp < 21'h20 || cp == 21'h7F || (cp >= 21'h80 && cp <= 21'h9F)) return 1'b1;
      foreach (span_lo[k]) begin
        if (cp >= span_lo[k] && cp <= span_hi[k]) return 1'b1;
      end
      return 1'b0;
    endfunction

    function void put_byte(bit [7:0] b);
      if (step_bytes.size() < 4) step_bytes.insert(step_bytes.size(), b);
    endfunction

    function void emit_code_point(bit [20:0] cp);
      if (hidden_cp(cp)) return;
      if (cp < 21'h80) begin
        put_byte(cp[7:0]);
      end else if (cp < 21'h800) begin
        put_byte({3'b110, cp[10:6]});
        put_byte({2'b10, cp[5:0]});
      end else if (cp < 21'h10000) begin
        put_byte({4'b1110, cp[15:12]});
        put_byte({2'b10, cp[11:6]});
        put_byte({2'b10, cp[5:0]});
      end else begin
        put_byte({5'b11110, cp[20:18]});
        put_byte({2'b10, cp[17:12]});
        put_byte({2'b10, cp[11:6]});
        put_byte({2'b10, cp[5:0]});
      end
    endfunction

    function void decode_feed(bit [7:0] b);
      bit [7:0] tail [$];
      bit [20:0] cp;
      int unsigned bad;
      int unsigned n;
      if (seq_cnt == 0) begin
        if (b < 8'h80) begin
          emit_code_point({13'b0, b});
        end else if (b[7:5] == 3'b110) begin
          seq_buf[0] = b; seq_cnt = 1; seq_len = 2;
        end else if (b[7:4] == 4'b1110) begin
          seq_buf[0] = b; seq_cnt = 1; seq_len = 3;
        end else if (b[7:3] == 5'b11110) begin
          seq_buf[0] = b; seq_cnt = 1; seq_len = 4;
        end
        return;
      end
      if (seq_cnt < 4) begin
        seq_buf[seq_cnt] = b;
        seq_cnt++;
      end
      if (seq_cnt < seq_len) return;
      n = seq_len;
      bad = 0;
      for (int j = 1; j < n; j++) begin
        if (bad == 0 && seq_buf[j][7:6] != 2'b10) bad = j;
      end
      seq_cnt = 0;
      seq_len = 0;
      if (bad == 0) begin
        case (n)
          2: cp = {16'b0, seq_buf[0][4:0]};
          3: cp = {17'b0, seq_buf[0][3:0]};
          default: cp = {18'b0, seq_buf[0][2:0]};
        endcase
        for (int j = 1; j < n; j++) cp = {cp[14:0], seq_buf[j][5:0]};
        emit_code_point(cp);
        return;
      end
      // bytes from the bad one onward start over as fresh text
      for (int j = bad; j < n; j++) tail.insert(tail.size(), seq_buf[j]);
      foreach (tail[k]) decode_feed(tail[k]);
    endfunction

    function void note_byte(in_t item);
      int n;
      out_t e;
      bytes_in++;
      step_bytes.delete();
      decode_feed(item.in_byte);
      if (item.text_last) begin
        seq_cnt = 0;
        seq_len = 0;
      end
      n = step_bytes.size();
      if (n == 0) begin
        if (item.text_last) begin
          e = '{8'h00, 1'b0, 1'b1, 1'b1};
          expected_bytes.insert(expected_bytes.size(), e);
        end
        return;
      end
      for (int k = 0; k < n; k++) begin
        e = '{step_bytes[k], 1'b1, k == n - 1, (k == n - 1) && item.text_last};
        expected_bytes.insert(expected_bytes.size(), e);
      end
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (expected_bytes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected output item: byte %02h valid %0d run_last %0d end %0d",
                   got.out_byte, got.byte_valid, got.run_last, got.text_end);
        return;
      end
      want = expected_bytes.pop_front();
      bytes_out++;
      if (got.out_byte !== want.out_byte || got.byte_valid !== want.byte_valid ||
          got.run_last !== want.run_last || got.text_end !== want.text_end) begin
        mismatches++;
        if (mismatches <= 10)
          $display("output item %0d: expected byte %02h valid %0d run_last %0d end %0d,",
                   bytes_out, want.out_byte, want.byte_valid, want.run_last,
                   want.text_end,
                   " got byte %02h valid %0d run_last %0d end %0d",
                   got.out_byte, got.byte_valid, got.run_last, got.text_end);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_t in_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_t out_o;

  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned cycle_cnt = 0;
  int unsigned texts_sent = 0;
  bit [7:0] text_q [$];
  sanitize_tracker sb = new();

  utf8_sanitize_filter_top DUT (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .in_i(in_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_o(out_o)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(out_o);
  end

  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  task automatic send_byte(input bit [7:0] b, input bit is_last);
    in_t item;
    item.in_byte = b;
    item.text_last = is_last;
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_i <= item;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_byte(item);
  endtask

  task automatic send_text();
    foreach (text_q[k]) send_byte(text_q[k], k == text_q.size() - 1);
    text_q.delete();
    texts_sent++;
  endtask

  // sender holds off until every expected output item has come back
  task automatic drain_outputs();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.expected_bytes.size() != 0) @(posedge clk_i);
  endtask

  function automatic void text_add(bit [7:0] b);
    text_q.insert(text_q.size(), b);
  endfunction

  function automatic bit [7:0] lead_byte(bit [20:0] cp, int len);
    case (len)
      2: return {3'b110, cp[10:6]};
      3: return {4'b1110, cp[15:12]};
      default: return {5'b11110, cp[20:18]};
    endcase
  endfunction

  // len may exceed the shortest form, which gives an overlong encoding
  function automatic void add_seq(bit [20:0] cp, int len);
    if (len == 1) begin
      text_add({1'b0, cp[6:0]});
      return;
    end
    text_add(lead_byte(cp, len));
    for (int k = len - 2; k >= 0; k--) text_add({2'b10, cp[6*k +: 6]});
  endfunction

  function automatic void add_unit();
    int r;
    int len;
    bit [20:0] cp;
    r = $urandom_range(99);
    cp = 21'($urandom);
    if (r < 35) begin
      text_add(8'($urandom_range(127)));
    end else if (r < 60) begin
      add_seq(cp, $urandom_range(2, 4));
    end else if (r < 75) begin
      cp = BORDER_CPS[$urandom_range(NUM_BORDER - 1)];
      len = (cp < 21'h80) ? 1 : (cp < 21'h800) ? 2 : (cp < 21'h10000) ? 3 : 4;
      add_seq(cp, len);
    end else if (r < 87) begin
      // lead, some good continuations, then a byte that is no continuation
      len = $urandom_range(2, 4);
      text_add(lead_byte(cp, len));
      repeat ($urandom_range(0, len - 2)) text_add(8'($urandom_range(8'h80, 8'hBF)));
      if ($urandom_range(1))
        text_add(8'($urandom_range(127)));
      else
        text_add(8'($urandom_range(8'hC0, 8'hFF)));
    end else begin
      text_add(8'($urandom_range(255)));
    end
  endfunction

  function automatic void build_text();
    int len;
    repeat ($urandom_range(1, 10)) add_unit();
    // some texts end in the middle of a sequence
    if ($urandom_range(99) < 15) begin
      len = $urandom_range(2, 4);
      text_add(lead_byte(21'($urandom), len));
      repeat ($urandom_range(0, len - 2)) text_add(8'($urandom_range(8'h80, 8'hBF)));
    end
  endfunction

  initial begin
    int unsigned phase_bytes;
    int unsigned idle_tab [4];
    int unsigned stall_tab [4];
    idle_tab = '{0, 87, 0, 8};
    stall_tab = '{0, 0, 87, 8};
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // ascii extremes, invalid leads, overlong form, combining mark, largest code
    // point, bad continuations with re-decode, cut-short end, data on the end
    text_q = '{8'h41, 8'h00, 8'h0A, 8'h7F, 8'hFF, 8'h80, 8'hC1, 8'h81, 8'hCC, 8'h80,
               8'hF7, 8'hBF, 8'hBF, 8'hBF, 8'hF0, 8'hE2, 8'h82, 8'hAC,
               8'hE2, 8'h41, 8'h42, 8'hE2, 8'h82};
    send_text();
    text_q = '{8'h5A};
    send_text();
    text_q = '{8'hF8};
    send_text();
    drain_outputs();

    for (int p = 0; p < 4; p++) begin
      idle_pct = idle_tab[p];
      stall_pct = stall_tab[p];
      phase_bytes = 0;
      while (phase_bytes < PHASE_BYTES) begin
        build_text();
        phase_bytes += text_q.size();
        send_text();
      end
      drain_outputs();
    end
    stall_pct = 0;
    repeat (20) @(posedge clk_i);

    $display("covered %0d input bytes in %0d texts and checked %0d output items",
             sb.bytes_in, texts_sent, sb.bytes_out);
    $display("pacing went free-running, sender-idle, receiver-stall and mixed; %0d mismatches",
             sb.mismatches);
    if (sb.mismatches == 0 && sb.expected_bytes.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[files.f]
hdl/usf_pkg.sv
hdl/usf_scan.sv
hdl/usf_emit.sv
hdl/utf8_sanitize_filter_top.sv
bench/tb.sv
